// File: src/bpm_pkg.sv
package bpm_pkg;

    localparam int ADC_W   = 16;
    localparam int MV_W    = 16;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 4;
    localparam int PCT_W   = 7;
    localparam int DIR_W   = 2;
    localparam int STAT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IFACE     = 3'd7;

    localparam logic [DIR_W-1:0] DIR_UNDET     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CHARGE    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DISCHARGE = 2'd2;

    typedef struct packed {
        logic [15:0] cell_min;
        logic [15:0] cell_max;
        logic [3:0]  cells;
        logic [15:0] ref_mv;
        logic [16:0] full_scale;
        logic [19:0] gain;
        logic [31:0] interval;
        logic        iface;
    } cfg_t;

    typedef struct packed {
        logic load;       // capture input beat
        logic mul1;       // raw * ref
        logic mul2;       // * gain
        logic div_start;  // begin divide
        logic div_step;   // one quotient bit
        logic accum;      // add scaled reading to sum
        logic fin_check;  // evaluate interface / count
        logic ring_wr;    // write sum into ring, limits
        logic ring_add;   // accumulate one ring entry
        logic ring_avg;   // finish average
        logic pct_start;
        logic pct_step;
        logic finish;     // register output beat
    } cmd_t;

    typedef struct packed {
        logic last;
        logic fail;
    } sts_t;

endpackage

// File: src/bpm_ctrl.sv
module bpm_ctrl #(
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          out_free,
    input  bpm_pkg::sts_t sts,
    output logic          busy,
    output bpm_pkg::cmd_t cmd
);
    localparam int RW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH + 1) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DSTART, S_DIV, S_ACC, S_CHECK,
        S_RWR, S_RADD, S_RAVG, S_PSTART, S_PCT, S_WAIT
    } state_t;

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [RW-1:0] ring_cnt_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.load      = in_fire;
        cmd.mul1      = (state_reg == S_MUL1);
        cmd.mul2      = (state_reg == S_MUL2);
        cmd.div_start = (state_reg == S_DSTART);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.accum     = (state_reg == S_ACC);
        cmd.fin_check = (state_reg == S_CHECK);
        cmd.ring_wr   = (state_reg == S_RWR);
        cmd.ring_add  = (state_reg == S_RADD);
        cmd.ring_avg  = (state_reg == S_RAVG);
        cmd.pct_start = (state_reg == S_PSTART);
        cmd.pct_step  = (state_reg == S_PCT);
        cmd.finish    = (state_reg == S_WAIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ring_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE:   if (in_fire) state_reg <= S_MUL1;
                S_MUL1:   state_reg <= S_MUL2;
                S_MUL2:   state_reg <= S_DSTART;
                S_DSTART: begin
                    state_reg <= S_DIV;
                    cnt_reg   <= 6'd0;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd16) state_reg <= S_ACC;
                end
                S_ACC:    state_reg <= sts.last ? S_CHECK : S_IDLE;
                S_CHECK:  state_reg <= sts.fail ? S_WAIT : S_RWR;
                S_RWR: begin
                    state_reg    <= S_RADD;
                    ring_cnt_reg <= '0;
                end
                S_RADD: begin
                    ring_cnt_reg <= ring_cnt_reg + 1'b1;
                    if (ring_cnt_reg == RW'(AVERAGE_DEPTH - 1)) state_reg <= S_RAVG;
                end
                S_RAVG:   state_reg <= S_PSTART;
                S_PSTART: begin
                    state_reg <= S_PCT;
                    cnt_reg   <= 6'd0;
                end
                S_PCT: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd25) state_reg <= S_WAIT;
                end
                S_WAIT:   if (out_free) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/bpm_datapath.sv
module bpm_datapath #(
    parameter int MAX_CELLS     = 8,
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  bpm_pkg::cfg_t cfg,
    input  bpm_pkg::cmd_t cmd,
    input  logic [15:0]   in_adc,
    input  logic          in_last,
    input  logic [15:0]   in_elapsed,
    output bpm_pkg::sts_t sts,
    output logic [41:0]   res_data
);
    localparam int PW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int TW = bpm_pkg::SUM_W + PW + 1;

    logic [15:0] adc_reg;
    logic        last_reg;
    logic [15:0] elapsed_reg;
    logic [31:0] prod1_reg;
    logic [51:0] prod2_reg;
    logic [18:0] rem_reg;
    logic        ovf_reg;
    logic [16:0] quo_reg;
    logic [18:0] sum_reg;
    logic [18:0] sum_reg_hold;
    logic [3:0]  count_reg;
    logic [18:0] ring_reg [AVERAGE_DEPTH];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] rd_reg;
    logic [TW-1:0] total_reg;
    logic [18:0] avg_reg;
    logic [18:0] prev_reg;
    logic [31:0] time_reg;
    logic [1:0]  dir_reg;
    logic        f_iface_reg, f_calc_reg, f_under_reg, f_over_reg;
    logic        fail_reg;
    logic [19:0] pmin_reg, pmax_reg;
    logic [25:0] pnum_reg;
    logic [19:0] prem_reg;
    logic [19:0] pden_reg;
    logic [6:0]  pquo_reg;
    logic [6:0]  pct_reg;
    logic        pzero_reg;

    logic [16:0] levels;
    logic [20:0] trial;
    logic [15:0] scaled;
    logic [19:0] sum_add;
    logic        count_ok;
    logic [21:0] ptrial;
    logic [32:0] tsum;
    logic [31:0] tsat;
    logic [7:0]  status;

    assign levels  = (cfg.full_scale == 17'd0) ? 17'd1 : cfg.full_scale;
    assign trial   = {1'b0, rem_reg, prod2_reg[32]} - {4'd0, levels};
    assign scaled  = (ovf_reg || quo_reg[16]) ? 16'hFFFF : quo_reg[15:0];
    assign sum_add = {1'b0, sum_reg} + {4'd0, scaled};
    assign count_ok = ((count_reg == cfg.cells) && ({1'b0, cfg.cells} <= 5'(MAX_CELLS)))
                   || ((cfg.cells > 4'd1) && (count_reg == 4'd1));
    assign ptrial  = {1'b0, prem_reg, pnum_reg[25]} - {2'd0, pden_reg};
    assign tsum    = {1'b0, time_reg} + {17'd0, elapsed_reg};
    assign tsat    = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
    assign sts.last = last_reg;
    assign sts.fail = !cfg.iface || !count_ok;

    always_comb begin
        status = '0;
        status[0] = (dir_reg == bpm_pkg::DIR_UNDET);
        status[1] = (dir_reg == bpm_pkg::DIR_CHARGE);
        status[2] = f_iface_reg;
        status[3] = f_calc_reg;
        status[6] = f_under_reg;
        status[7] = f_over_reg;
    end

    assign res_data = {status, dir_reg, fail_reg ? 7'd0 : pct_reg, avg_reg,
                       1'b0, 4'd0, ~fail_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            adc_reg     <= in_adc;
            last_reg    <= in_last;
            elapsed_reg <= in_elapsed;
        end
        if (cmd.mul1) prod1_reg <= adc_reg * cfg.ref_mv;
        if (cmd.mul2) prod2_reg <= prod1_reg * cfg.gain;
        if (cmd.div_start) begin
            // divide the product by 2^16 first; upper 19 bits seed the remainder
            rem_reg <= prod2_reg[51:33];
            ovf_reg <= (prod2_reg[51:33] >= {2'd0, levels});
            quo_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!trial[20]) begin
                rem_reg <= trial[18:0];
            end else begin
                rem_reg <= {rem_reg[17:0], prod2_reg[32]};
            end
            quo_reg   <= {quo_reg[15:0], ~trial[20]};
            prod2_reg <= {prod2_reg[50:0], 1'b0};
        end
        if (cmd.ring_add) begin
            total_reg <= total_reg + TW'(ring_reg[rd_reg]);
            rd_reg    <= rd_reg + 1'b1;
        end
        if (cmd.ring_wr) begin
            total_reg <= '0;
            rd_reg    <= '0;
            pmin_reg  <= {4'd0, cfg.cell_min} * {16'd0, cfg.cells};
            pmax_reg  <= {4'd0, cfg.cell_max} * {16'd0, cfg.cells};
        end
        if (cmd.pct_start) begin
            pnum_reg  <= 26'({1'b0, avg_reg} - pmin_reg) * 26'd100;
            prem_reg  <= '0;
            pden_reg  <= pmax_reg - pmin_reg;
            pquo_reg  <= '0;
            pzero_reg <= (pmax_reg == pmin_reg);
        end
        if (cmd.pct_step) begin
            if (!ptrial[21]) begin
                prem_reg <= ptrial[19:0];
            end else begin
                prem_reg <= {prem_reg[18:0], pnum_reg[25]};
            end
            pnum_reg <= {pnum_reg[24:0], 1'b0};
            pquo_reg <= {pquo_reg[5:0], ~ptrial[21]};
            if ({1'b0, avg_reg} < pmin_reg) pct_reg <= '0;
            else if ({1'b0, avg_reg} > pmax_reg) pct_reg <= 7'd100;
            else if (pzero_reg) pct_reg <= '0;
            else pct_reg <= {pquo_reg[5:0], ~ptrial[21]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            pos_reg     <= '0;
            avg_reg     <= '0;
            prev_reg    <= '0;
            time_reg    <= '0;
            dir_reg     <= bpm_pkg::DIR_UNDET;
            f_iface_reg <= 1'b0;
            f_calc_reg  <= 1'b0;
            f_under_reg <= 1'b0;
            f_over_reg  <= 1'b0;
            fail_reg    <= 1'b0;
            for (int i = 0; i < AVERAGE_DEPTH; i++) ring_reg[i] <= '0;
        end else begin
            if (cmd.accum) begin
                sum_reg <= sum_add[19] ? 19'h7FFFF : sum_add[18:0];
                if (count_reg != 4'hF) count_reg <= count_reg + 4'd1;
            end
            if (cmd.fin_check) begin
                sum_reg   <= '0;
                count_reg <= '0;
                if (!cfg.iface) begin
                    f_iface_reg <= 1'b1;
                    fail_reg    <= 1'b1;
                end else if (!count_ok) begin
                    f_calc_reg <= 1'b1;
                    avg_reg    <= '0;
                    fail_reg   <= 1'b1;
                end else begin
                    fail_reg <= 1'b0;
                end
            end
            if (cmd.ring_wr) begin
                ring_reg[pos_reg] <= sum_reg_hold;
                pos_reg <= (pos_reg == PW'(AVERAGE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (cmd.ring_avg) avg_reg <= 19'(total_reg / AVERAGE_DEPTH);
            if (cmd.pct_start && !fail_reg) begin
                if (tsat > cfg.interval) begin
                    dir_reg  <= (avg_reg > prev_reg) ? bpm_pkg::DIR_CHARGE
                                                     : bpm_pkg::DIR_DISCHARGE;
                    prev_reg <= avg_reg;
                    time_reg <= '0;
                end else begin
                    time_reg <= tsat;
                end
                f_iface_reg <= 1'b0;
                f_calc_reg  <= 1'b0;
                f_over_reg  <= {1'b0, avg_reg} > pmax_reg;
                f_under_reg <= {1'b0, avg_reg} < pmin_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_check) sum_reg_hold <= sum_reg;
    end
endmodule

// File: src/battery_pack_monitor_top.sv
// Battery pack monitor. Each s_ beat is one raw ADC reading; a reading is
// scaled by a multiply (reference, then gain) and a restoring divide, and
// s_tready stays low until the scaling, and for a tlast beat the whole
// update, is done. The beat with tlast closes the update and yields one m_
// beat after a count check, a ring write, the ring sum and average and a
// 26-step percent divide; updates that fail the interface or count check
// skip the ring and percent steps. A result held by m_tready low keeps the
// next update from finishing. One beat is in work at a time.
module battery_pack_monitor_top #(
    parameter int MAX_CELLS     = 8,
    parameter int AVERAGE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // adc_value[15:0], elapsed_ms[31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // update_ok, pack_mv, charge_percent, charge_state, status_bits
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    bpm_pkg::cfg_t cfg_reg;
    bpm_pkg::cmd_t cmd;
    bpm_pkg::sts_t sts;
    logic          busy;
    logic          in_fire;
    logic          out_free;
    logic [41:0]   res;
    logic [36:0]   out_reg;
    logic          mvalid_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {3'd0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_min   <= 16'd3000;
            cfg_reg.cell_max   <= 16'd4200;
            cfg_reg.cells      <= 4'd1;
            cfg_reg.ref_mv     <= 16'd3300;
            cfg_reg.full_scale <= 17'd4096;
            cfg_reg.gain       <= 20'd65536;
            cfg_reg.interval   <= 32'd1000;
            cfg_reg.iface      <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bpm_pkg::REG_CELL_MIN: cfg_reg.cell_min   <= cfg_data[15:0];
                bpm_pkg::REG_CELL_MAX: cfg_reg.cell_max   <= cfg_data[15:0];
                bpm_pkg::REG_CELLS:    cfg_reg.cells      <= cfg_data[3:0];
                bpm_pkg::REG_REF:      cfg_reg.ref_mv     <= cfg_data[15:0];
                bpm_pkg::REG_FULL:     cfg_reg.full_scale <= cfg_data[16:0];
                bpm_pkg::REG_GAIN:     cfg_reg.gain       <= cfg_data[19:0];
                bpm_pkg::REG_INTERVAL: cfg_reg.interval   <= cfg_data;
                bpm_pkg::REG_IFACE:    cfg_reg.iface      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            if (m_tready) mvalid_reg <= 1'b0;
            if (cmd.finish) mvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) out_reg <= {res[41:34], res[33:32], res[31:25], res[24:6], res[0]};
    end

    bpm_ctrl #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) u_ctrl (
        .aclk, .aresetn, .in_fire, .out_free, .sts, .busy, .cmd
    );

    bpm_datapath #(.MAX_CELLS(MAX_CELLS), .AVERAGE_DEPTH(AVERAGE_DEPTH)) u_dp (
        .aclk, .aresetn, .cfg(cfg_reg), .cmd,
        .in_adc(s_tdata[15:0]), .in_last(s_tlast), .in_elapsed(s_tdata[31:16]),
        .sts, .res_data(res)
    );
endmodule

// File: src/bpm_checker.sv
module bpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");
    a_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> !m_tvalid || $past(m_tvalid))
        else $error("result without last");
    a_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:20] <= 7'd100)
        else $error("percent out of range");
endmodule

bind battery_pack_monitor_top bpm_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready, .m_tdata
);

// File: tb/tb_battery_pack_monitor_top.sv
module tb_battery_pack_monitor_top;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DEPTH = 8;
    localparam int CELLS_MAX = 8;
    localparam int SETTLE = 90;
    localparam logic [3:0] F_IFACE = 4'd1;
    localparam logic [3:0] F_CALC  = 4'd2;
    localparam logic [3:0] F_UNDER = 4'd4;
    localparam logic [3:0] F_OVER  = 4'd8;

    typedef struct {
        logic                       ok;
        logic [bpm_pkg::SUM_W-1:0]  mv;
        logic [bpm_pkg::PCT_W-1:0]  pct;
        logic [bpm_pkg::DIR_W-1:0]  dir;
        logic [bpm_pkg::STAT_W-1:0] stat;
    } report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    battery_pack_monitor_top #(.MAX_CELLS(CELLS_MAX), .AVERAGE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bpm_pkg::cfg_t pack_cfg;
    logic [bpm_pkg::SUM_W-1:0] sum_mv;
    int unsigned reading_cnt;
    logic [bpm_pkg::SUM_W-1:0] avg_ring [DEPTH];
    int unsigned ring_pos;
    logic [bpm_pkg::SUM_W-1:0] avg_mv, prev_mv;
    logic [31:0] time_acc;
    logic [bpm_pkg::DIR_W-1:0] direction;
    logic [3:0]  flags;

    report_t     report_q[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    int          hold_left = 0;
    int          rx_gap = 0;
    bit          steady = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] scale_mv(logic [15:0] raw);
        longint unsigned levels, num, mv;
        levels = (pack_cfg.full_scale == 0) ? 1 : pack_cfg.full_scale;
        num = longint'(raw) * pack_cfg.ref_mv * pack_cfg.gain;
        mv = num / (levels << 16);
        return (mv > 65535) ? 16'hFFFF : mv[15:0];
    endfunction

    task automatic predict_beat(logic [15:0] raw, logic last, logic [15:0] elapsed);
        report_t r;
        int unsigned pmin, pmax, s;
        longint unsigned total, q;
        s = sum_mv + scale_mv(raw);
        sum_mv = (s > 524287) ? 19'h7FFFF : s[bpm_pkg::SUM_W-1:0];
        if (reading_cnt < 15) reading_cnt++;
        if (!last) return;
        r.ok = 0;
        r.pct = 0;
        if (!pack_cfg.iface) begin
            flags |= F_IFACE;
        end else if (!((reading_cnt == pack_cfg.cells && pack_cfg.cells <= CELLS_MAX) ||
                       (pack_cfg.cells > 1 && reading_cnt == 1))) begin
            flags |= F_CALC;
            avg_mv = 0;
        end else begin
            pmin = pack_cfg.cell_min * pack_cfg.cells;
            pmax = pack_cfg.cell_max * pack_cfg.cells;
            r.ok = 1;
            avg_ring[ring_pos] = sum_mv;
            ring_pos = (ring_pos + 1) % DEPTH;
            total = 0;
            foreach (avg_ring[i]) total += avg_ring[i];
            q = total / DEPTH;
            avg_mv = q[bpm_pkg::SUM_W-1:0];
            if (avg_mv < pmin) r.pct = 0;
            else if (avg_mv > pmax) r.pct = 100;
            else if (pmax == pmin) r.pct = 0;
            else begin
                q = (longint'(avg_mv - pmin) * 100) / (pmax - pmin);
                r.pct = q[bpm_pkg::PCT_W-1:0];
            end
            time_acc = (time_acc > 32'hFFFFFFFF - elapsed) ? 32'hFFFFFFFF : time_acc + elapsed;
            if (time_acc > pack_cfg.interval) begin
                direction = (avg_mv > prev_mv) ? bpm_pkg::DIR_CHARGE : bpm_pkg::DIR_DISCHARGE;
                prev_mv = avg_mv;
                time_acc = 0;
            end
            flags = 0;
            if (avg_mv > pmax) flags |= F_OVER;
            if (avg_mv < pmin) flags |= F_UNDER;
        end
        sum_mv = 0;
        reading_cnt = 0;
        r.mv = avg_mv;
        r.dir = direction;
        r.stat = {(flags & F_OVER) != 0, (flags & F_UNDER) != 0, 2'b00,
                  (flags & F_CALC) != 0, (flags & F_IFACE) != 0,
                  direction == bpm_pkg::DIR_CHARGE, direction == bpm_pkg::DIR_UNDET};
        report_q.push_back(r);
    endtask

    task automatic check_report(logic [39:0] d);
        report_t e, g;
        g.ok = d[0];
        g.mv = d[19:1];
        g.pct = d[26:20];
        g.dir = d[28:27];
        g.stat = d[36:29];
        if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", d);
            return;
        end
        e = report_q.pop_front();
        if (g.ok !== e.ok || g.mv !== e.mv || g.pct !== e.pct || g.dir !== e.dir ||
            g.stat !== e.stat || d[39:37] !== 3'b000) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp ok=%0d mv=%0d pct=%0d dir=%0d st=%h got ok=%0d mv=%0d pct=%0d dir=%0d st=%h",
                         e.ok, e.mv, e.pct, e.dir, e.stat, g.ok, g.mv, g.pct, g.dir, g.stat);
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) check_report(m_tdata);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
        end
    end

    task automatic send_beat(logic [15:0] raw, logic last, logic [15:0] elapsed);
        int gap;
        gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {elapsed, raw};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(raw, last, elapsed);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            bpm_pkg::REG_CELL_MIN: pack_cfg.cell_min = val[15:0];
            bpm_pkg::REG_CELL_MAX: pack_cfg.cell_max = val[15:0];
            bpm_pkg::REG_CELLS:    pack_cfg.cells = val[3:0];
            bpm_pkg::REG_REF:      pack_cfg.ref_mv = val[15:0];
            bpm_pkg::REG_FULL:     pack_cfg.full_scale = val[16:0];
            bpm_pkg::REG_GAIN:     pack_cfg.gain = val[19:0];
            bpm_pkg::REG_INTERVAL: pack_cfg.interval = val;
            default:               pack_cfg.iface = val[0];
        endcase
    endtask

    task automatic apply_cfg(bpm_pkg::cfg_t c);
        drain();
        write_cfg(bpm_pkg::REG_CELL_MIN, 32'(c.cell_min));
        write_cfg(bpm_pkg::REG_CELL_MAX, 32'(c.cell_max));
        write_cfg(bpm_pkg::REG_CELLS, 32'(c.cells));
        write_cfg(bpm_pkg::REG_REF, 32'(c.ref_mv));
        write_cfg(bpm_pkg::REG_FULL, 32'(c.full_scale));
        write_cfg(bpm_pkg::REG_GAIN, 32'(c.gain));
        write_cfg(bpm_pkg::REG_INTERVAL, c.interval);
        write_cfg(bpm_pkg::REG_IFACE, 32'(c.iface));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // raw reading that lands near a chosen millivolt value; some calls return a random reading
    function automatic logic [15:0] raw_for_mv(int unsigned mv);
        longint unsigned den, r;
        den = longint'(pack_cfg.ref_mv) * pack_cfg.gain;
        if (den == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
        r = (longint'(mv) * ((pack_cfg.full_scale == 0) ? 1 : pack_cfg.full_scale) << 16) / den;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic send_update(int n);
        int lo, hi;
        lo = (pack_cfg.cell_min > 400) ? pack_cfg.cell_min - 400 : 0;
        hi = pack_cfg.cell_max + 400;
        if (n == 1 && pack_cfg.cells > 1) begin
            lo *= pack_cfg.cells;
            hi *= pack_cfg.cells;
        end
        for (int i = 0; i < n; i++)
            send_beat(raw_for_mv($urandom_range(lo, hi)), i == n - 1,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 400)));
    endtask

    function automatic bpm_pkg::cfg_t default_cfg();
        bpm_pkg::cfg_t c;
        c.cell_min = 3000; c.cell_max = 4200; c.cells = 1; c.ref_mv = 3300;
        c.full_scale = 4096; c.gain = 65536; c.interval = 1000; c.iface = 1;
        return c;
    endfunction

    task automatic test_single_cell();
        send_beat(16'h0000, 1, 16'h0000);
        send_beat(16'hFFFF, 1, 16'hFFFF);
        send_beat(16'd4000, 1, 16'd1200);
        send_beat(16'd2048, 1, 16'd5);
        send_beat(16'd4095, 1, 16'd2000);
    endtask

    task automatic test_counts();
        bpm_pkg::cfg_t c;
        c = default_cfg();
        c.cells = 4;
        apply_cfg(c);
        send_update(4);
        send_update(1);
        send_update(3);
        send_update(5);
        send_update(18);
        c.cells = 12;
        apply_cfg(c);
        send_update(12);
        send_update(1);
        c.cells = 0;
        apply_cfg(c);
        send_update(1);
    endtask

    task automatic test_register_extremes();
        bpm_pkg::cfg_t c;
        c = default_cfg();
        c.iface = 0;
        apply_cfg(c);
        send_update(1);
        c = '{cell_min: 16'hFFFF, cell_max: 16'hFFFF, cells: 4'd8, ref_mv: 16'hFFFF,
              full_scale: 17'd0, gain: 20'hFFFFF, interval: 32'hFFFFFFFF, iface: 1'b1};
        apply_cfg(c);
        send_beat(16'hFFFF, 0, 16'hFFFF);
        for (int i = 0; i < 7; i++) send_beat(16'hFFFF, i == 6, 16'hFFFF);
        c = '{cell_min: 16'd0, cell_max: 16'd0, cells: 4'd1, ref_mv: 16'd0,
              full_scale: 17'h1FFFF, gain: 20'd0, interval: 32'd0, iface: 1'b1};
        apply_cfg(c);
        send_beat(16'd100, 1, 16'd1);
        c = '{cell_min: 16'd3500, cell_max: 16'd3500, cells: 4'd1, ref_mv: 16'd3300,
              full_scale: 17'h10000, gain: 20'd65536, interval: 32'd0, iface: 1'b1};
        apply_cfg(c);
        send_beat(16'd0, 1, 16'd0);
        send_beat(16'd65535, 1, 16'd3);
    endtask

    task automatic test_backpressure();
        apply_cfg(default_cfg());
        hold_left = 500;
        for (int i = 0; i < 8; i++) send_update(1);
        drain();
    endtask

    task automatic test_random();
        bpm_pkg::cfg_t c;
        int beats, n;
        beats = 0;
        while (beats < 1000) begin
            c.cells = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            c.cell_min = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(2500, 3500));
            c.cell_max = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : 16'(c.cell_min + $urandom_range(0, 1500));
            c.ref_mv = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1800, 5000));
            c.full_scale = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                           : (17'd1 << $urandom_range(8, 16));
            c.gain = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                 : 20'($urandom_range(60000, 70000));
            c.interval = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1500);
            c.iface = ($urandom_range(0, 15) != 0);
            apply_cfg(c);
            steady = ($urandom_range(0, 4) == 0);
            for (int u = 0; u < 25; u++) begin
                case ($urandom_range(0, 9))
                    0: n = 1;
                    1: n = $urandom_range(0, 17);
                    default: n = (c.cells == 0) ? 1 : c.cells;
                endcase
                if (n == 0) begin
                    send_beat(16'($urandom), 0, 16'($urandom));
                    n = 1;
                end
                send_update(n);
                beats += n;
            end
            steady = 0;
        end
    endtask

    initial begin
        pack_cfg = default_cfg();
        sum_mv = 0; reading_cnt = 0; ring_pos = 0;
        foreach (avg_ring[i]) avg_ring[i] = 0;
        avg_mv = 0; prev_mv = 0; time_acc = 0; direction = bpm_pkg::DIR_UNDET; flags = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_cell();
        test_counts();
        test_register_extremes();
        test_backpressure();
        test_random();
        drain();
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
